// File: src/api_frame_receive_deframer_unit_defines.svh
// assertion macros for the frame deframer
`ifndef API_FRAME_RECEIVE_DEFRAMER_UNIT_DEFINES_SVH
`define API_FRAME_RECEIVE_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define AFRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbl failed");

// next-cycle implication
`define AFRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

// File: src/afrd_pkg.sv
`default_nettype none
package afrd_pkg;

  localparam int MAX_DATA_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int LEN_W = 17;

  localparam logic [7:0] DELIM      = 8'h7E;
  localparam logic [7:0] TYPE_MODEM = 8'h8A;
  localparam logic [7:0] NO_ID      = 8'hFF;
  localparam logic [7:0] ASSOC_A    = 8'h02;
  localparam logic [7:0] ASSOC_B    = 8'h06;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_GOOD    = 3'd2;
  localparam logic [2:0] EV_BADSUM  = 3'd3;
  localparam logic [2:0] EV_TOOLONG = 3'd4;
  localparam logic [2:0] EV_MODEM   = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE,
    PH_ID,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_delim;
    logic       has_id;
    logic       is_modem;
    logic       is_assoc;
  } item_t;

  typedef struct packed {
    logic       associated;
    logic [8:0] frame_length;
    logic [7:0] frame_id;
    logic [7:0] frame_type;
    logic [7:0] data_index;
    logic [7:0] data_byte;
    logic [2:0] event_res;
  } result_t;

  function automatic logic type_has_id(input logic [7:0] t);
    return (t == 8'h00) || (t == 8'h08) || (t == 8'h17) ||
           (t == 8'h88) || (t == 8'h89) || (t == 8'h97);
  endfunction

endpackage
`default_nettype wire

// File: src/api_frame_receive_deframer_unit.sv
// Byte-serial API frame deframer. Takes one received byte per transaction and
// returns exactly one result transaction per byte: the event code, the byte,
// the payload index and the current frame's type, id, data length and the
// association flag. Sustained rate is one byte per clock while m_axis_tready
// stays high. An accepted byte is written into a two-entry queue and is popped
// once the output register is empty or being drained; its result is registered
// at that pop, so each byte passes through a queue slot and the result register.
// While the output is stalled the queue soaks up bytes until both entries are
// taken (one byte when the stream was flowing back to back, two when it was
// empty), then tready drops. Frames whose data length is negative or above
// MAX_DATA_BYTES end with a too-long event on the first byte after the header.
`default_nettype none
`include "api_frame_receive_deframer_unit_defines.svh"
module api_frame_receive_deframer_unit #(
  parameter int MAX_DATA_BYTES = afrd_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // event_res[2:0], data_byte[10:3], data_index[18:11], frame_type[26:19],
  // frame_id[34:27], frame_length[43:35], associated[44], zero fill[47:45]
  output logic [47:0]      m_axis_tdata
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  afrd_pkg::item_t push_item;
  afrd_pkg::item_t pop_item;

  afrd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  afrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (pop_item)
  );

  afrd_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `AFRD_ASSERT_IMP(a_full_only_when_stalled, !s_axis_tready, m_axis_tvalid)
  `AFRD_ASSERT_IMP(a_toolong_no_length,
    m_axis_tvalid && (m_axis_tdata[2:0] == afrd_pkg::EV_TOOLONG),
    m_axis_tdata[43:35] == 9'd0)
  `AFRD_ASSERT_IMP(a_modem_type,
    m_axis_tvalid && (m_axis_tdata[2:0] == afrd_pkg::EV_MODEM),
    m_axis_tdata[26:19] == afrd_pkg::TYPE_MODEM)
  `AFRD_ASSERT_NXT(a_pop_gives_result, q_pop, m_axis_tvalid)

endmodule
`default_nettype wire

// File: src/afrd_front.sv
`default_nettype none
module afrd_front (
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,
  input  wire logic          q_full,
  output logic               q_push,
  output afrd_pkg::item_t    q_item
);

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    q_item.rx_byte  = s_axis_tdata;
    q_item.is_delim = (s_axis_tdata == afrd_pkg::DELIM);
    q_item.has_id   = afrd_pkg::type_has_id(s_axis_tdata);
    q_item.is_modem = (s_axis_tdata == afrd_pkg::TYPE_MODEM);
    q_item.is_assoc = (s_axis_tdata == afrd_pkg::ASSOC_A) ||
                      (s_axis_tdata == afrd_pkg::ASSOC_B);
  end

endmodule
`default_nettype wire

// File: src/afrd_queue.sv
`default_nettype none
module afrd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire afrd_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output afrd_pkg::item_t      pop_item
);

  localparam int PTR_W = (afrd_pkg::QUEUE_DEPTH > 1) ? $clog2(afrd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(afrd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(afrd_pkg::QUEUE_DEPTH - 1);

  afrd_pkg::item_t slots [afrd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(afrd_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/afrd_back.sv
`default_nettype none
module afrd_back #(
  parameter int MAX_DATA_BYTES = afrd_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire afrd_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [47:0]          m_axis_tdata
);

  localparam int CNT_W = $clog2(MAX_DATA_BYTES + 1);
  localparam int LW = afrd_pkg::LEN_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_DATA_BYTES);

  afrd_pkg::phase_t phase, phase_next;
  logic [LW-1:0]    data_len, data_len_next;
  logic [CNT_W-1:0] rx_count, rx_count_next;
  logic [7:0]       run_sum, run_sum_next;
  logic [7:0]       held_type, held_type_next;
  logic [7:0]       held_id, held_id_next;
  logic             held_modem, held_modem_next;
  logic             first_assoc, first_assoc_next;
  logic             assoc_flag, assoc_flag_next;

  afrd_pkg::result_t res, res_next;
  logic              out_valid;
  logic [2:0]        ev;
  logic [7:0]        b;
  logic [7:0]        sum_add;
  logic              cur_len_ok;
  logic              next_len_ok;
  logic [CNT_W-1:0]  idx;

  assign q_pop         = q_valid && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, res};

  assign b          = q_item.rx_byte;
  assign sum_add    = run_sum + b;
  assign cur_len_ok = !data_len[LW-1] && (data_len <= MAX_LEN);

  // phase sequencing
  always_comb begin
    phase_next = phase;
    case (phase)
      afrd_pkg::PH_IDLE: begin
        if (q_item.is_delim) begin
          phase_next = afrd_pkg::PH_LEN_HI;
        end
      end
      afrd_pkg::PH_LEN_HI: phase_next = afrd_pkg::PH_LEN_LO;
      afrd_pkg::PH_LEN_LO: phase_next = afrd_pkg::PH_TYPE;
      afrd_pkg::PH_TYPE: begin
        phase_next = q_item.has_id ? afrd_pkg::PH_ID : afrd_pkg::PH_DATA;
      end
      afrd_pkg::PH_ID: phase_next = afrd_pkg::PH_DATA;
      afrd_pkg::PH_DATA: begin
        if (!cur_len_ok || !(LW'(rx_count) < data_len)) begin
          phase_next = afrd_pkg::PH_IDLE;
        end
      end
      default: phase_next = afrd_pkg::PH_IDLE;
    endcase
  end

  // frame datapath and event
  always_comb begin
    data_len_next    = data_len;
    rx_count_next    = rx_count;
    run_sum_next     = run_sum;
    held_type_next   = held_type;
    held_id_next     = held_id;
    held_modem_next  = held_modem;
    first_assoc_next = first_assoc;
    assoc_flag_next  = assoc_flag;
    ev               = afrd_pkg::EV_NONE;
    case (phase)
      afrd_pkg::PH_LEN_HI: begin
        data_len_next = {1'b0, b, 8'h00};
      end
      afrd_pkg::PH_LEN_LO: begin
        data_len_next    = {1'b0, data_len[15:8], b} - LW'(2);
        rx_count_next    = '0;
        run_sum_next     = '0;
        first_assoc_next = 1'b0;
      end
      afrd_pkg::PH_TYPE: begin
        held_type_next  = b;
        held_modem_next = q_item.is_modem;
        run_sum_next    = b;
        if (!q_item.has_id) begin
          held_id_next  = afrd_pkg::NO_ID;
          data_len_next = data_len + LW'(1);
        end
      end
      afrd_pkg::PH_ID: begin
        held_id_next = b;
        run_sum_next = sum_add;
      end
      afrd_pkg::PH_DATA: begin
        if (!cur_len_ok) begin
          ev = afrd_pkg::EV_TOOLONG;
        end else if (LW'(rx_count) < data_len) begin
          if (rx_count == '0) begin
            first_assoc_next = q_item.is_assoc;
          end
          run_sum_next  = sum_add;
          rx_count_next = rx_count + 1'b1;
          ev            = afrd_pkg::EV_PAYLOAD;
        end else begin
          run_sum_next = sum_add;
          if (sum_add == afrd_pkg::SUM_GOOD) begin
            if (held_modem) begin
              assoc_flag_next = first_assoc;
              ev              = afrd_pkg::EV_MODEM;
            end else begin
              ev = afrd_pkg::EV_GOOD;
            end
          end else begin
            ev = afrd_pkg::EV_BADSUM;
          end
        end
      end
      default: ev = afrd_pkg::EV_NONE;
    endcase
  end

  assign next_len_ok = !data_len_next[LW-1] && (data_len_next <= MAX_LEN);
  assign idx = (ev == afrd_pkg::EV_PAYLOAD) ? rx_count : rx_count_next;

  always_comb begin
    res_next.event_res    = ev;
    res_next.data_byte    = b;
    res_next.data_index   = 8'(idx);
    res_next.frame_type   = held_type_next;
    res_next.frame_id     = held_id_next;
    res_next.frame_length = next_len_ok ? data_len_next[8:0] : 9'd0;
    res_next.associated   = assoc_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= afrd_pkg::PH_IDLE;
      data_len    <= '0;
      rx_count    <= '0;
      run_sum     <= '0;
      held_type   <= '0;
      held_id     <= '0;
      held_modem  <= 1'b0;
      first_assoc <= 1'b0;
      assoc_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        phase       <= phase_next;
        data_len    <= data_len_next;
        rx_count    <= rx_count_next;
        run_sum     <= run_sum_next;
        held_type   <= held_type_next;
        held_id     <= held_id_next;
        held_modem  <= held_modem_next;
        first_assoc <= first_assoc_next;
        assoc_flag  <= assoc_flag_next;
        out_valid   <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire
